>>> hdl/wildcard_glob_matcher_defines.svh
// Assertion macros shared by the glob matcher checker.
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WGM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define WGM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define WGM_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/wgm_pkg.sv
// Shared constants, types and helpers of the wildcard glob matcher.
`default_nettype none

package wgm_pkg;

   localparam int PATTERN_MAX_DEFAULT = 32;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_QUERY   = 8'h3F;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   typedef enum logic [1:0] {
      FUNC_CLEAR   = 2'd0,
      FUNC_APPEND  = 2'd1,
      FUNC_SUBJECT = 2'd2
   } func_type;

   typedef struct packed {
      logic clear;
      logic write;
      logic rearm;
      logic step;
   } cell_ctl_type;

   function automatic logic [7:0] fold_lower(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
         r = c - CHAR_UPPER_A + CHAR_LOWER_A;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/wgm_cell.sv
// One pattern position: stored character, its active bit and the hand-off to the next position.
`default_nettype none

module wgm_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire wgm_pkg::cell_ctl_type ctl,
   input  wire logic                  seed,
   input  wire logic                  wr_sel,
   input  wire logic [7:0]            wr_char,
   input  wire logic [7:0]            subj_char,
   input  wire logic                  carry_in,
   input  wire logic                  step_in,
   output logic                       carry_out,
   output logic                       step_out,
   output logic                       active_out
);

   logic [7:0] char_ff;
   logic [7:0] char_in;
   logic       star_ff;
   logic       star_in;
   logic       query_ff;
   logic       query_in;
   logic       used_ff;
   logic       used_in;
   logic       raw_ff;
   logic       raw_in;
   logic       wr_en;
   logic       active;

   assign wr_en    = ctl.write & wr_sel;
   assign char_in  = wgm_pkg::fold_lower(wr_char);
   assign star_in  = (wr_char == wgm_pkg::CHAR_STAR);
   assign query_in = (wr_char == wgm_pkg::CHAR_QUERY);

   // A position is active if it was reached directly or through a run of stars on its left.
   assign active     = raw_ff | carry_in;
   assign active_out = active;
   assign carry_out  = active & used_ff & star_ff;
   assign step_out   = active & used_ff & ~star_ff & (query_ff | (char_ff == subj_char));

   always_comb begin
      used_in = used_ff;
      raw_in  = raw_ff;
      if (ctl.clear) begin
         used_in = 1'b0;
      end
      if (wr_en) begin
         used_in = 1'b1;
      end
      if (ctl.rearm) begin
         raw_in = seed;
      end else if (ctl.step) begin
         raw_in = step_in | carry_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         raw_ff  <= seed;
      end else begin
         used_ff <= used_in;
         raw_ff  <= raw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         char_ff  <= char_in;
         star_ff  <= star_in;
         query_ff <= query_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/wildcard_glob_matcher.sv
// Top level of the wildcard glob matcher: control, a chain of position cells and the result register.
// A new beat is taken each cycle unless a result waits and is stalled.
// The end-of-subject beat yields its result in the cycle after acceptance; the active set moves
// one subject byte per cycle unless stalled, and star runs close in the same cycle along the chain.
// Reset empties the pattern, clears the overflow flag and arms position zero.
`default_nettype none

module wildcard_glob_matcher #(
   parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_func,
   input  wire logic [7:0] req_char_code,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_matched,
   output logic            rsp_pattern_overflow
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   wgm_pkg::cell_ctl_type ctl;
   logic [LEN_W-1:0]      len_ff;
   logic [LEN_W-1:0]      len_in;
   logic                  overflow_ff;
   logic                  overflow_in;
   logic                  final_raw_ff;
   logic                  final_raw_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_matched_ff;
   logic                  rsp_pattern_overflow_ff;
   logic                  accept;
   logic                  end_beat;
   logic                  full;
   logic [7:0]            subj_char;
   logic [PATTERN_MAX:0]  carry;
   logic [PATTERN_MAX:0]  step;
   logic [PATTERN_MAX:0]  active_vec;

   assign req_stall            = rsp_valid_ff & rsp_stall;
   assign accept               = req_valid & ~req_stall;
   assign full                 = (len_ff == LEN_W'(PATTERN_MAX));
   assign subj_char            = wgm_pkg::fold_lower(req_char_code);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = rsp_matched_ff;
   assign rsp_pattern_overflow = rsp_pattern_overflow_ff;

   assign carry[0] = 1'b0;
   assign step[0]  = 1'b0;

   for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
      wgm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .seed       ((g == 0) ? 1'b1 : 1'b0),
         .wr_sel     (len_ff == LEN_W'(g)),
         .wr_char    (req_char_code),
         .subj_char  (subj_char),
         .carry_in   (carry[g]),
         .step_in    (step[g]),
         .carry_out  (carry[g+1]),
         .step_out   (step[g+1]),
         .active_out (active_vec[g])
      );
   end

   assign active_vec[PATTERN_MAX] = final_raw_ff | carry[PATTERN_MAX];

   always_comb begin
      ctl          = '0;
      len_in       = len_ff;
      overflow_in  = overflow_ff;
      end_beat     = 1'b0;
      if (accept) begin
         case (wgm_pkg::func_type'(req_func))
            wgm_pkg::FUNC_CLEAR: begin
               ctl.clear   = 1'b1;
               ctl.rearm   = 1'b1;
               len_in      = '0;
               overflow_in = 1'b0;
            end
            wgm_pkg::FUNC_APPEND: begin
               if (req_char_code != wgm_pkg::CHAR_NUL) begin
                  ctl.rearm = 1'b1;
                  if (full) begin
                     overflow_in = 1'b1;
                  end else begin
                     ctl.write = 1'b1;
                     len_in    = len_ff + LEN_W'(1);
                  end
               end
            end
            wgm_pkg::FUNC_SUBJECT: begin
               if (req_char_code != wgm_pkg::CHAR_NUL) begin
                  ctl.step = 1'b1;
               end else begin
                  ctl.rearm = 1'b1;
                  end_beat  = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      final_raw_in = final_raw_ff;
      if (ctl.rearm) begin
         final_raw_in = 1'b0;
      end else if (ctl.step) begin
         final_raw_in = step[PATTERN_MAX];
      end
   end

   assign rsp_valid_in = end_beat | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         overflow_ff  <= 1'b0;
         final_raw_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         overflow_ff  <= overflow_in;
         final_raw_ff <= final_raw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (end_beat) begin
         rsp_matched_ff          <= active_vec[len_ff];
         rsp_pattern_overflow_ff <= overflow_ff;
      end
   end

endmodule

`default_nettype wire

>>> hdl/wgm_checker.sv
// Port-level checker for the wildcard glob matcher and its bind to the top level.
`default_nettype none

`include "wildcard_glob_matcher_defines.svh"

module wgm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic [1:0] req_func,
   input wire logic [7:0] req_char_code,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_matched,
   input wire logic       rsp_pattern_overflow
);

   logic req_beat;
   logic end_of_subject;

   assign req_beat       = req_valid & ~req_stall;
   assign end_of_subject = (req_func == wgm_pkg::FUNC_SUBJECT) &&
                           (req_char_code == wgm_pkg::CHAR_NUL);

   `WGM_ASSERT_ALWAYS(a_reset_empties_output, clock, reset, !rsp_valid, "result valid after reset")

   `WGM_ASSERT_NOW(a_stall_only_when_blocked, clock, reset, req_stall, rsp_valid && rsp_stall, "input stalled while result register free")

   `WGM_ASSERT_NEXT(a_end_gives_result, clock, reset, req_beat && end_of_subject, rsp_valid, "end of subject gave no result")

   `WGM_ASSERT_NEXT(a_no_spurious_result, clock, reset, req_beat && !end_of_subject && (!rsp_valid || !rsp_stall), !rsp_valid, "result appeared without end of subject")

   `WGM_ASSERT_NEXT(a_stalled_result_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_matched) && $stable(rsp_pattern_overflow), "stalled result changed")

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (.*);

`default_nettype wire

>>> bench/glob_match_checker.sv
// Checker for the glob matcher: tracks the pattern and live positions, predicts and compares.
module glob_match_checker #(
   parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_func,
   input  logic [7:0] req_char_code,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_matched,
   input  logic       rsp_pattern_overflow,
   output int         failures,
   output int         pending
);

   typedef struct packed {
      logic matched;
      logic overflow;
   } glob_outcome_type;

   logic [7:0]           pat_chars [PATTERN_MAX];
   int unsigned          pat_len = 0;
   logic [PATTERN_MAX:0] live = (PATTERN_MAX + 1)'(1);
   logic                 ovf = 1'b0;
   glob_outcome_type     expected_outcomes [$];
   int                   fail_count = 0;
   int                   pending_count = 0;

   assign failures = fail_count;
   assign pending  = pending_count;

   function automatic logic [7:0] lower_byte(input logic [7:0] c);
      return (c >= wgm_pkg::CHAR_UPPER_A && c <= wgm_pkg::CHAR_UPPER_Z) ?
             8'(c - wgm_pkg::CHAR_UPPER_A + wgm_pkg::CHAR_LOWER_A) : c;
   endfunction

   function automatic void close_stars();
      for (int i = 0; i < pat_len; i++) begin
         if (live[i] && pat_chars[i] == wgm_pkg::CHAR_STAR) begin
            live[i + 1] = 1'b1;
         end
      end
   endfunction

   function automatic void restart();
      live = '0;
      live[0] = 1'b1;
      close_stars();
   endfunction

   function automatic void consume(input logic [7:0] c);
      logic [PATTERN_MAX:0] nxt;
      nxt = '0;
      for (int i = 0; i < pat_len; i++) begin
         if (live[i]) begin
            if (pat_chars[i] == wgm_pkg::CHAR_STAR) begin
               nxt[i] = 1'b1;
            end else if (pat_chars[i] == wgm_pkg::CHAR_QUERY ||
                         lower_byte(pat_chars[i]) == lower_byte(c)) begin
               nxt[i + 1] = 1'b1;
            end
         end
      end
      live = nxt;
      close_stars();
   endfunction

   function automatic void apply_beat(input logic [1:0] f, input logic [7:0] c);
      glob_outcome_type outcome;
      case (f)
         wgm_pkg::FUNC_CLEAR: begin
            pat_len = 0;
            ovf = 1'b0;
            restart();
         end
         wgm_pkg::FUNC_APPEND: begin
            if (c != wgm_pkg::CHAR_NUL) begin
               if (pat_len < PATTERN_MAX) begin
                  pat_chars[pat_len] = c;
                  pat_len++;
               end else begin
                  ovf = 1'b1;
               end
               restart();
            end
         end
         wgm_pkg::FUNC_SUBJECT: begin
            if (c != wgm_pkg::CHAR_NUL) begin
               consume(c);
            end else begin
               outcome.matched = live[pat_len];
               outcome.overflow = ovf;
               expected_outcomes.push_back(outcome);
               restart();
            end
         end
         default: begin
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      glob_outcome_type want;
      if (reset) begin
         pat_len = 0;
         ovf = 1'b0;
         restart();
         expected_outcomes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch("result beat with no outcome pending");
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_matched !== want.matched) begin
                  report_mismatch($sformatf("matched is %b, predicted %b",
                                            rsp_matched, want.matched));
               end
               if (rsp_pattern_overflow !== want.overflow) begin
                  report_mismatch($sformatf("pattern_overflow is %b, predicted %b",
                                            rsp_pattern_overflow, want.overflow));
               end
            end
         end
         if (req_valid && !req_stall) begin
            apply_beat(req_func, req_char_code);
         end
      end
      pending_count <= expected_outcomes.size();
   end

endmodule

>>> bench/tb_top.sv
// Testbench top for the glob matcher: clock, reset, pattern and subject stimulus, and the verdict.
module tb_top;

   localparam int         PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEFAULT;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT = 300000;
   localparam int         LONG_HOLD   = 300;
   localparam logic [7:0] FOLD_EDGES [6] = '{8'h40, 8'h5A, 8'h5B, 8'h60, 8'h7A, 8'h7B};

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_func;
   logic [7:0] req_char_code;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_matched;
   logic       rsp_pattern_overflow;
   int         failures;
   int         pending;

   int         cycle_count = 0;
   int         items_sent = 0;
   int         send_idle_pct = 0;
   int         stall_pct = 0;
   logic       hold_request = 1'b0;
   logic [7:0] pattern_copy [$];
   logic [7:0] subject_buf [$];

   wildcard_glob_matcher #(.PATTERN_MAX(PATTERN_MAX)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_char_code(req_char_code),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_matched(rsp_matched),
      .rsp_pattern_overflow(rsp_pattern_overflow)
   );

   glob_match_checker #(.PATTERN_MAX(PATTERN_MAX)) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_char_code(req_char_code),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_matched(rsp_matched),
      .rsp_pattern_overflow(rsp_pattern_overflow),
      .failures(failures),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // The long hold is counted here, once it has been requested.
   initial begin : stall_gen
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic send_beat(input logic [1:0] f, input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_char_code <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!(f == FUNC_UNUSED || (f == wgm_pkg::FUNC_APPEND && c == wgm_pkg::CHAR_NUL))) begin
         items_sent++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic clear_pattern();
      send_beat(wgm_pkg::FUNC_CLEAR, 8'($urandom_range(255)));
      pattern_copy.delete();
   endtask

   task automatic append_char(input logic [7:0] c);
      send_beat(wgm_pkg::FUNC_APPEND, c);
      if (c != wgm_pkg::CHAR_NUL && pattern_copy.size() < PATTERN_MAX) begin
         pattern_copy.push_back(c);
      end
   endtask

   task automatic end_subject();
      send_beat(wgm_pkg::FUNC_SUBJECT, wgm_pkg::CHAR_NUL);
   endtask

   task automatic send_subject();
      foreach (subject_buf[i]) send_beat(wgm_pkg::FUNC_SUBJECT, subject_buf[i]);
      end_subject();
   endtask

   function automatic logic [7:0] pick_char();
      int r;
      r = int'($urandom_range(99));
      if (r < 30) return 8'(wgm_pkg::CHAR_LOWER_A + $urandom_range(2));
      if (r < 45) return 8'(wgm_pkg::CHAR_UPPER_A + $urandom_range(2));
      if (r < 55) return wgm_pkg::CHAR_STAR;
      if (r < 65) return wgm_pkg::CHAR_QUERY;
      if (r < 75) return FOLD_EDGES[$urandom_range(5)];
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic bit is_letter(input logic [7:0] c);
      return (c >= wgm_pkg::CHAR_UPPER_A && c <= wgm_pkg::CHAR_UPPER_Z) ||
             (c >= wgm_pkg::CHAR_LOWER_A && c <= "z");
   endfunction

   task automatic build_matching_subject();
      logic [7:0] c;
      int r;
      subject_buf.delete();
      foreach (pattern_copy[i]) begin
         c = pattern_copy[i];
         if (c == wgm_pkg::CHAR_STAR) begin
            repeat ($urandom_range(0, 3)) subject_buf.push_back(pick_char());
         end else if (c == wgm_pkg::CHAR_QUERY) begin
            subject_buf.push_back(pick_char());
         end else begin
            if (is_letter(c) && $urandom_range(1)) c = c ^ 8'h20;
            subject_buf.push_back(c);
         end
      end
      r = int'($urandom_range(99));
      if (r < 10) begin
         subject_buf.insert($urandom_range(subject_buf.size()), pick_char());
      end else if (r < 18 && subject_buf.size() > 0) begin
         subject_buf.delete($urandom_range(subject_buf.size() - 1));
      end else if (r < 25 && subject_buf.size() > 0) begin
         subject_buf[$urandom_range(subject_buf.size() - 1)] = pick_char();
      end
   endtask

   task automatic random_subject();
      subject_buf.delete();
      repeat ($urandom_range(0, 5)) subject_buf.push_back(pick_char());
   endtask

   task automatic send_noise();
      case ($urandom_range(3))
         0: send_beat(FUNC_UNUSED, 8'($urandom_range(255)));
         1: append_char(wgm_pkg::CHAR_NUL);
         2: begin
            repeat ($urandom_range(1, 3)) send_beat(wgm_pkg::FUNC_SUBJECT, pick_char());
            if ($urandom_range(1)) clear_pattern();
            else append_char(pick_char());
         end
         default: begin
            random_subject();
            send_subject();
         end
      endcase
   endtask

   task automatic run_sequence();
      int r;
      int len;
      r = int'($urandom_range(99));
      if (r < 20) begin
         clear_pattern();
         len = ($urandom_range(9) == 0) ? int'($urandom_range(20, 36)) :
                                          int'($urandom_range(0, 6));
         repeat (len) append_char(pick_char());
      end else if (r < 82) begin
         build_matching_subject();
         send_subject();
      end else if (r < 90) begin
         send_noise();
      end else if (r < 97) begin
         random_subject();
         send_subject();
      end else begin
         drain();
      end
   endtask

   initial begin
      int send_pcts [4];
      int stall_pcts [4];
      int target;
      send_pcts = '{0, 64, 0, 21};
      stall_pcts = '{0, 0, 64, 21};
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = wgm_pkg::FUNC_CLEAR;
      req_char_code = wgm_pkg::CHAR_NUL;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty cases, folding, wildcards, ignored beats and edits mid-subject.
      end_subject();
      send_beat(wgm_pkg::FUNC_SUBJECT, "b");
      end_subject();
      append_char("A");
      append_char(wgm_pkg::CHAR_STAR);
      append_char(wgm_pkg::CHAR_QUERY);
      send_beat(wgm_pkg::FUNC_SUBJECT, "a");
      send_beat(wgm_pkg::FUNC_SUBJECT, 8'hFF);
      send_beat(wgm_pkg::FUNC_SUBJECT, "Z");
      end_subject();
      append_char(wgm_pkg::CHAR_NUL);
      send_beat(FUNC_UNUSED, 8'hAA);
      send_beat(wgm_pkg::FUNC_SUBJECT, "a");
      append_char(wgm_pkg::CHAR_STAR);
      end_subject();
      clear_pattern();
      send_beat(wgm_pkg::FUNC_SUBJECT, 8'h80);
      end_subject();
      append_char(wgm_pkg::CHAR_STAR);
      end_subject();
      append_char(8'h5B);
      send_beat(wgm_pkg::FUNC_SUBJECT, 8'h7B);
      end_subject();
      drain();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_pcts[p];
         stall_pct = stall_pcts[p];
         if (p == 0) hold_request <= 1'b1;
         target = items_sent + 420;
         while (items_sent < target) run_sequence();
         drain();
      end

      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> wildcard_glob_matcher.f
+incdir+hdl
hdl/wgm_pkg.sv
hdl/wgm_cell.sv
hdl/wildcard_glob_matcher.sv
hdl/wgm_checker.sv
bench/glob_match_checker.sv
bench/tb_top.sv
